// ===== rtl/core/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbse_pkg
// Shared types and constants for the LSB steganography extractor.
// ----------------------------------------------------------------------------
package lsbse_pkg;

  // Default end marker length, in bytes
  localparam int unsigned MARKER_LEN_DEF = 7;
  localparam int unsigned MARKER_TABLE_LEN = 16;

  // End marker "$!EOM!$"; the unused tail is zero and can never match
  localparam logic [7:0] END_MARKER [MARKER_TABLE_LEN] = '{
    8'h24, 8'h21, 8'h45, 8'h4F, 8'h4D, 8'h21, 8'h24, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       is_last;
  } lsbse_res_t;

endpackage

// ===== rtl/core/lsbse_in_if.sv =====
// ----------------------------------------------------------------------------
// lsbse_in_if
// Input channel: one colour channel byte per word.
// ----------------------------------------------------------------------------
interface lsbse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_byte;
  logic       last_channel;

  modport source (output valid, output channel_byte, output last_channel, input ready);
  modport sink   (input valid, input channel_byte, input last_channel, output ready);
endinterface

// ===== rtl/core/lsbse_out_if.sv =====
// ----------------------------------------------------------------------------
// lsbse_out_if
// Output channel: recovered message byte or closing status per word.
// ----------------------------------------------------------------------------
interface lsbse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       is_last;

  modport source (output valid, output data_byte, output status, output is_last, input ready);
  modport sink   (input valid, input data_byte, input status, input is_last, output ready);
endinterface

// ===== rtl/core/lsbse_cell.sv =====
// ----------------------------------------------------------------------------
// lsbse_cell
// One byte of the look-back window: holds a decoded byte, hands it to the
// older neighbour on each push and compares it with its marker character.
// ----------------------------------------------------------------------------
module lsbse_cell #(
  parameter logic [7:0] MARKER_BYTE = 8'h00
) (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_q == MARKER_BYTE);

endmodule

// ===== rtl/core/lsbse_out_buf.sv =====
// ----------------------------------------------------------------------------
// lsbse_out_buf
// Two-entry output buffer: registered result plus a skid entry, so the
// decoder's ready never waits on the consumer's ready; it drops only when
// both entries are full.
// ----------------------------------------------------------------------------
module lsbse_out_buf
  import lsbse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lsbse_res_t push_data_i,
  output logic       space_o,
  input  logic       pop_ready_i,
  output logic       valid_o,
  output lsbse_res_t data_o
);

  lsbse_res_t e0_q, e0_d;
  lsbse_res_t e1_q, e1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = e0_q;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    e0_d  = e0_q;
    e1_d  = e1_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
    if (pop) begin
      if (cnt_q == 2'd2) begin
        e0_d = e1_q;
      end else if (push_i) begin
        e0_d = push_data_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        e0_d = push_data_i;
      end else begin
        e1_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

// ===== rtl/core/lsb_stego_extract_core.sv =====
// ----------------------------------------------------------------------------
// lsb_stego_extract_core
// Recovers a message from the least significant bits of image channel bytes.
// ----------------------------------------------------------------------------
// Takes one channel byte per cycle while the buffer has space and returns at
// most one registered word per input word. Bit 0 of each channel byte is packed
// into a message byte, first bit lowest. Decoded bytes pass through a row of
// MARKER_LEN-1 window cells that shift on every completed byte; each cell
// compares itself with its marker character, so the end marker is found in
// the cycle its last byte completes. A byte is sent (status data) once it
// leaves the window. On a match a found word closes the image and the rest of
// it is skipped up to the last channel; at the last channel without a match a
// not-found word closes it, and bytes already sent are to be discarded. After
// a zero byte no match is possible in that image. A two-entry output buffer
// holds words while the consumer stalls; the input is held off only once both
// entries are full.
// ----------------------------------------------------------------------------
module lsb_stego_extract_core
  import lsbse_pkg::*;
#(
  parameter int unsigned MARKER_LEN = MARKER_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsbse_in_if.sink  in_i,
  lsbse_out_if.source out_o
);

  localparam int unsigned NCELL   = (MARKER_LEN > 1) ? MARKER_LEN - 1 : 1;
  localparam int unsigned FW      = $clog2(MARKER_LEN + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(MARKER_LEN - 1);
  localparam logic [7:0] LAST_MARK = END_MARKER[MARKER_LEN - 1];

  logic [2:0]    cnt_q, cnt_d;
  logic [7:0]    partial_q, partial_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          zero_q, zero_d;
  logic          found_q, found_d;

  logic          in_fire;
  logic          buf_space;
  logic [7:0]    byte_new;
  logic          byte_done;
  logic          push;
  logic          win_match;
  logic          res_valid;
  lsbse_res_t    res;
  lsbse_res_t    out_res;

  logic [7:0]    cell_byte  [NCELL];
  logic [NCELL-1:0] cell_match;

  assign in_i.ready = buf_space;
  assign in_fire    = in_i.valid && buf_space;
  assign byte_new   = partial_q | ({7'd0, in_i.channel_byte[0]} << cnt_q);
  assign byte_done  = (cnt_q == 3'd7);
  assign win_match  = !zero_q && (fill_q == FILL_MAX) && (&cell_match)
                      && (byte_new == LAST_MARK);

  // Window row: newest byte enters the tail, the oldest leaves at cell 0
  generate
    if (MARKER_LEN > 1) begin : g_win
      for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic [7:0] feed;
        if (k == NCELL - 1) begin : g_tail
          assign feed = byte_new;
        end else begin : g_mid
          assign feed = cell_byte[k+1];
        end
        lsbse_cell #(
          .MARKER_BYTE (END_MARKER[k])
        ) u_cell (
          .clk_i   (clk_i),
          .shift_i (push),
          .byte_i  (feed),
          .byte_o  (cell_byte[k]),
          .match_o (cell_match[k])
        );
      end
    end else begin : g_nowin
      assign cell_byte[0]  = byte_new;
      assign cell_match[0] = 1'b1;
    end
  endgenerate

  always_comb begin
    cnt_d     = cnt_q;
    partial_d = partial_q;
    fill_d    = fill_q;
    zero_d    = zero_q;
    found_d   = found_q;
    push      = 1'b0;
    res_valid = 1'b0;
    res       = '{data_byte: 8'd0, status: ST_DATA, is_last: 1'b0};
    if (in_fire) begin
      if (found_q) begin
        // skip the rest of the image
        if (in_i.last_channel) begin
          found_d = 1'b0;
          zero_d  = 1'b0;
          fill_d  = '0;
        end
      end else if (!byte_done) begin
        cnt_d     = cnt_q + 3'd1;
        partial_d = byte_new;
        if (in_i.last_channel) begin
          cnt_d     = 3'd0;
          partial_d = 8'd0;
          fill_d    = '0;
          zero_d    = 1'b0;
          res_valid = 1'b1;
          res       = '{data_byte: 8'd0, status: ST_NOT_FOUND, is_last: 1'b1};
        end
      end else begin
        cnt_d     = 3'd0;
        partial_d = 8'd0;
        if (win_match) begin
          res_valid = 1'b1;
          res       = '{data_byte: 8'd0, status: ST_FOUND, is_last: 1'b1};
          if (in_i.last_channel) begin
            fill_d = '0;
            zero_d = 1'b0;
          end else begin
            found_d = 1'b1;
          end
        end else if (in_i.last_channel) begin
          fill_d    = '0;
          zero_d    = 1'b0;
          res_valid = 1'b1;
          res       = '{data_byte: 8'd0, status: ST_NOT_FOUND, is_last: 1'b1};
        end else begin
          push = 1'b1;
          if (byte_new == 8'd0) begin
            zero_d = 1'b1;
          end
          if (fill_q != FILL_MAX) begin
            fill_d = fill_q + FW'(1);
          end else begin
            // oldest byte leaves the window
            res_valid = 1'b1;
            res       = '{data_byte: cell_byte[0], status: ST_DATA, is_last: 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 3'd0;
      partial_q <= 8'd0;
      fill_q    <= '0;
      zero_q    <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      partial_q <= partial_d;
      fill_q    <= fill_d;
      zero_q    <= zero_d;
      found_q   <= found_d;
    end
  end

  lsbse_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (buf_space),
    .pop_ready_i (out_o.ready),
    .valid_o     (out_o.valid),
    .data_o      (out_res)
  );

  assign out_o.data_byte = out_res.data_byte;
  assign out_o.status    = out_res.status;
  assign out_o.is_last   = out_res.is_last;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("window fill above capacity");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && found_q) |-> !res_valid && !push)
    else $error("result or window push while skipping image");

  a_image_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.last_channel) |=> (fill_q == '0) && !found_q && !zero_q
                                       && (cnt_q == 3'd0))
    else $error("state not cleared after last channel");
`endif

endmodule

// ===== tb/lsbse_msg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbse_msg_checker
// Watches both channels of the extractor. Decodes the accepted channel bytes
// with its own model of the bit packing, the marker window and the image
// state. Compares every output word, field by field, with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module lsbse_msg_checker
  import lsbse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lsbse_in_if  in_mon,
  lsbse_out_if out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned WIN = MARKER_LEN_DEF - 1;

  logic [2:0]  bits_held;
  logic [7:0]  byte_acc;
  logic [7:0]  held [WIN];
  int unsigned held_cnt;
  logic        saw_zero;
  logic        skipping;

  lsbse_res_t  owed_words [$];
  int          owed_n = 0;
  int          fails = 0;
  int unsigned words_seen = 0;

  assign fail_count_o = fails;
  assign pending_o    = owed_n;

  task automatic report_mismatch(input string what);
    $display("%0t ns: word %0d: %s", $time, words_seen, what);
    fails++;
  endtask

  function automatic void clear_image();
    bits_held = '0;
    byte_acc  = '0;
    for (int k = 0; k < WIN; k++) held[k] = '0;
    held_cnt  = 0;
    saw_zero  = 1'b0;
    skipping  = 1'b0;
  endfunction

  function automatic lsbse_res_t closing_word(input status_e st);
    lsbse_res_t r;
    r.data_byte = '0;
    r.status    = st;
    r.is_last   = 1'b1;
    return r;
  endfunction

  // Advance the decoder by one channel byte and queue the word it causes
  function automatic void decode_channel(input logic [7:0] cb, input logic lst);
    logic [7:0] b;
    logic       hit;
    lsbse_res_t r;
    if (skipping) begin
      if (lst) clear_image();
      return;
    end
    byte_acc[bits_held] = cb[0];
    bits_held = bits_held + 3'd1;
    if (bits_held != 3'd0) begin
      if (lst) begin
        clear_image();
        owed_words.push_back(closing_word(ST_NOT_FOUND));
      end
      return;
    end
    b = byte_acc;
    byte_acc = '0;
    // a match needs a full window of marker bytes and no zero in this image
    hit = !saw_zero && (held_cnt == WIN) && (b == END_MARKER[WIN]);
    for (int k = 0; k < WIN; k++) begin
      if (held[k] != END_MARKER[k]) hit = 1'b0;
    end
    if (hit) begin
      if (lst) clear_image();
      else skipping = 1'b1;
      owed_words.push_back(closing_word(ST_FOUND));
      return;
    end
    if (lst) begin
      clear_image();
      owed_words.push_back(closing_word(ST_NOT_FOUND));
      return;
    end
    if (b == 8'h00) saw_zero = 1'b1;
    if (held_cnt < WIN) begin
      held[held_cnt] = b;
      held_cnt++;
      return;
    end
    r.data_byte = held[0];
    r.status    = ST_DATA;
    r.is_last   = 1'b0;
    owed_words.push_back(r);
    for (int k = 0; k + 1 < WIN; k++) held[k] = held[k + 1];
    held[WIN - 1] = b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lsbse_res_t want;
    if (!rst_ni) begin
      clear_image();
      owed_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_channel(in_mon.channel_byte, in_mon.last_channel);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word data %h status %0d last %b",
                                    out_mon.data_byte, out_mon.status, out_mon.is_last));
        end else begin
          want = owed_words.pop_front();
          if (out_mon.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, want %h",
                                      out_mon.data_byte, want.data_byte));
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status %0d, want %s",
                                      out_mon.status, want.status.name()));
          if (out_mon.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %b, want %b",
                                      out_mon.is_last, want.is_last));
        end
        words_seen++;
      end
    end
    owed_n = owed_words.size();
  end

endmodule

// ===== tb/tb_lsb_stego_extract_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lsb_stego_extract_core
// Feeds the extractor short images built from hidden messages: with and
// without the end marker, with zero bytes, near misses and plain noise, under
// random stalls on both sides. A checker beside the block predicts and
// compares every word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_lsb_stego_extract_core;
  import lsbse_pkg::*;

  localparam int unsigned ITEM_GOAL  = 1700;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned TAIL_WAIT  = 20;

  typedef enum int {
    IMG_MARKER_TAIL,
    IMG_MARKER_LAST,
    IMG_ZERO_BLOCK,
    IMG_NEAR_MISS,
    IMG_NO_MARKER,
    IMG_NOISE,
    IMG_KINDS
  } img_kind_e;

  logic        clk_i;
  logic        rst_ni;
  int          fail_count;
  int          pending;
  bit          quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  lsbse_in_if  in_bus ();
  lsbse_out_if out_bus ();

  lsb_stego_extract_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  lsbse_msg_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic put_channel(input logic [7:0] cb, input bit lst, input bit counted);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.channel_byte <= cb;
    in_bus.last_channel <= lst;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (counted) items_sent++;
  endtask

  // Hide one message byte in eight channels, first bit lowest
  task automatic put_msg_byte(input logic [7:0] b, input bit lst, input bit counted);
    logic [7:0] cb;
    for (int i = 0; i < 8; i++) begin
      cb    = 8'($urandom());
      cb[0] = b[i];
      put_channel(cb, lst && (i == 7), counted);
    end
  endtask

  task automatic put_noise(input int unsigned n, input bit counted);
    for (int unsigned i = 0; i < n; i++)
      put_channel(8'($urandom()), i == n - 1, counted);
  endtask

  task automatic put_marker(input bit lst);
    for (int k = 0; k < MARKER_LEN_DEF; k++)
      put_msg_byte(END_MARKER[k], lst && (k == MARKER_LEN_DEF - 1), 1'b1);
  endtask

  // Hold the input until every predicted word has come out
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_image(input img_kind_e kind);
    int unsigned n_msg;
    logic [7:0]  b;
    n_msg = $urandom_range(0, 5);
    case (kind)
      IMG_MARKER_TAIL, IMG_MARKER_LAST, IMG_ZERO_BLOCK: begin
        for (int unsigned i = 0; i < n_msg; i++)
          put_msg_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
        if (kind == IMG_ZERO_BLOCK) begin
          put_msg_byte(8'h00, 1'b0, 1'b1);
          for (int unsigned i = $urandom_range(0, 8); i > 0; i--)
            put_msg_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
        end
        put_marker(kind == IMG_MARKER_LAST);
        // after a find the tail is skipped, so it does not count
        if (kind != IMG_MARKER_LAST) put_noise($urandom_range(1, 12), kind == IMG_ZERO_BLOCK);
      end
      IMG_NEAR_MISS: begin
        for (int unsigned i = 0; i < n_msg; i++)
          put_msg_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
        for (int unsigned k = $urandom_range(1, MARKER_LEN_DEF - 1), j = 0; j < k; j++)
          put_msg_byte(END_MARKER[j], 1'b0, 1'b1);
        put_msg_byte(8'($urandom_range(1, 255)), 1'b0, 1'b1);
        put_marker(1'b0);
        put_noise($urandom_range(1, 12), 1'b0);
      end
      IMG_NO_MARKER: begin
        for (int unsigned i = $urandom_range(4, 20); i > 0; i--) begin
          b = ($urandom_range(0, 1) == 0) ? END_MARKER[$urandom_range(0, MARKER_LEN_DEF - 1)]
                                          : 8'($urandom());
          put_msg_byte(b, 1'b0, 1'b1);
        end
        put_noise($urandom_range(1, 8), 1'b1);
      end
      IMG_NOISE: put_noise($urandom_range(1, 40), 1'b1);
      default: ;
    endcase
  endtask

  // Output side: before every word, hold ready low for a random stall, none when quiet
  initial begin
    int unsigned gap;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned img;
    img_kind_e   kind;
    rst_ni              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.channel_byte <= '0;
    in_bus.last_channel <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-channel image: closes with no marker mid-byte
    put_channel(8'hFF, 1'b1, 1'b1);
    // last channel completes a byte without a match
    put_channel(8'h00, 1'b0, 1'b1);
    put_channel(8'hFF, 1'b0, 1'b1);
    put_channel(8'hFE, 1'b0, 1'b1);
    put_channel(8'h01, 1'b0, 1'b1);
    put_channel(8'h80, 1'b0, 1'b1);
    put_channel(8'h7F, 1'b0, 1'b1);
    put_channel(8'h55, 1'b0, 1'b1);
    put_channel(8'hAA, 1'b1, 1'b1);
    put_channel(8'h01, 1'b0, 1'b1);
    put_channel(8'hFE, 1'b1, 1'b1);
    drain();

    img = 0;
    while (items_sent < ITEM_GOAL) begin
      quiet = ($urandom_range(0, 3) == 0);
      kind  = (img < IMG_KINDS) ? img_kind_e'(img)
                                : img_kind_e'($urandom_range(0, IMG_KINDS - 1));
      send_image(kind);
      if ($urandom_range(0, 4) == 0) drain();
      img++;
    end

    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
